// ===== sv/csl_pkg.sv =====
`default_nettype none

package csl_pkg;

    // default build
    localparam int NUM_STAGES_DEF  = 10;
    localparam int SAMPLE_BITS_DEF = 24;

    // datapath widths
    localparam int VW     = 40;   // stage value, Q8.31
    localparam int RW     = 42;   // rounded product result
    localparam int ACC_W  = 66;   // multiply-accumulate register
    localparam int CHUNK  = 20;   // multiplicand slice per cycle
    localparam int BW     = 25;   // multiplier operand, signed
    localparam int QW     = 17;   // Q0.16 coefficients, 1.0 included

    // configuration port
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 24;
    localparam logic [CFG_AW-1:0] REG_BASE  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_FIRST = 2'd1;
    localparam logic [CFG_AW-1:0] REG_HALO  = 2'd2;
    localparam logic [CFG_AW-1:0] REG_MIX   = 2'd3;

    // register reset values
    localparam logic [23:0] BASE_RST  = 24'd8388;
    localparam logic [3:0]  FIRST_RST = 4'd0;
    localparam logic [16:0] HALO_RST  = 17'd0;
    localparam logic [16:0] MIX_RST   = 17'd65536;

    // fixed-point constants
    localparam logic [23:0]   INVPHI_Q24 = 24'd10368890;  // 1/phi
    localparam logic [QW-1:0] ONE_Q16    = 17'd65536;
    localparam logic [15:0]   HALO78_Q16 = 16'd51118;     // 0.78

    // 40-bit saturation bounds, held at accumulator width
    localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (VW - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(1) <<< (VW - 1));

    typedef logic signed [VW-1:0] t_val;

    // clamp a wide signed value to the 40-bit stage range
    function automatic t_val sat40(input logic signed [ACC_W-1:0] v);
        t_val r;
        if (v > SAT_HI) begin
            r = SAT_HI[VW-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[VW-1:0];
        end else begin
            r = v[VW-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/cascaded_slew_limiter.sv =====
`default_nettype none

// Channel     Dir  Handshake                       Payload
// ----------  ---  ------------------------------  ------------------------------
// s_axis      in   s_axis_tvalid / s_axis_tready   tdata: sample_in
// m_axis      out  m_axis_tvalid / m_axis_tready   tdata: sample_out
// cfg         in   i_cfg_we (no wait)              i_cfg_addr, i_cfg_data
//
// One 21x25 multiplier with a 66-bit accumulator does all the multiplies; a
// 40-bit operand takes two passes. Each active stage steps through load,
// products, evaluate and done; a new word is accepted only once the last has
// been loaded into the output register, which lets the next word in while a
// result waits. After reset and after every register write the threshold
// ladder and halo terms are rebuilt with s_axis_tready low. Reset is
// synchronous, active low, and clears the stage history and trend references.

module cascaded_slew_limiter #(
    parameter int NUM_STAGES  = csl_pkg::NUM_STAGES_DEF,
    parameter int SAMPLE_BITS = csl_pkg::SAMPLE_BITS_DEF
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    // input stream
    input  wire                                      s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire  [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,  // sample_in
    // output stream
    output logic                                     m_axis_tvalid,
    input  wire                                      m_axis_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,  // sample_out
    // configuration writes
    input  wire                                      i_cfg_we,
    input  wire  [csl_pkg::CFG_AW-1:0]               i_cfg_addr,
    input  wire  [csl_pkg::CFG_DW-1:0]               i_cfg_data
);

    localparam int TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int UP_SHIFT  = 32 - SAMPLE_BITS;
    localparam int MIX_SHIFT = 16 + UP_SHIFT;
    localparam int SW        = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
    localparam int VW        = csl_pkg::VW;
    localparam int RW        = csl_pkg::RW;
    localparam int ACC_W     = csl_pkg::ACC_W;
    localparam int CHUNK     = csl_pkg::CHUNK;
    localparam int BW        = csl_pkg::BW;
    localparam int QW        = csl_pkg::QW;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_TMUL  = 3'd2;
    localparam logic [2:0] S_TCAP  = 3'd3;
    localparam logic [2:0] S_HMUL  = 3'd4;
    localparam logic [2:0] S_HCAP  = 3'd5;
    localparam logic [2:0] S_STAGE = 3'd6;
    localparam logic [2:0] S_MIX   = 3'd7;

    // stage steps; products run in steps 1..12, low slice then high slice
    localparam logic [3:0] ST_LOAD     = 4'd0;
    localparam logic [3:0] ST_CAP_PRED = 4'd3;
    localparam logic [3:0] ST_CAP_DH   = 4'd5;
    localparam logic [3:0] ST_CAP_TH   = 4'd7;
    localparam logic [3:0] ST_CAP_DH78 = 4'd9;
    localparam logic [3:0] ST_CAP_TH78 = 4'd11;
    localparam logic [3:0] ST_MUL_LAST = 4'd12;
    localparam logic [3:0] ST_EVAL     = 4'd13;
    localparam logic [3:0] ST_DONE     = 4'd14;
    localparam logic [3:0] ST_OUT      = 4'd4;   // mix: result ready
    localparam logic [3:0] ST_MIX_LAST = 4'd3;

    // stage products
    localparam logic [2:0] OP_PRED = 3'd0;   // d * 1/phi
    localparam logic [2:0] OP_DH   = 3'd1;   // d * h
    localparam logic [2:0] OP_TH   = 3'd2;   // t * (1-h)
    localparam logic [2:0] OP_DH78 = 3'd3;   // d * h78
    localparam logic [2:0] OP_TH78 = 3'd4;   // t * (1-h78)
    localparam logic [2:0] OP_REF  = 3'd5;   // p * (1-h)

    localparam logic signed [BW-1:0] B_INVPHI = BW'(csl_pkg::INVPHI_Q24);
    localparam logic signed [BW-1:0] B_HALO78 = BW'(csl_pkg::HALO78_Q16);

    localparam logic signed [ACC_W-1:0] RC_16  = ACC_W'(1) <<< 15;
    localparam logic signed [ACC_W-1:0] RC_24  = ACC_W'(1) <<< 23;
    localparam logic signed [ACC_W-1:0] RC_MIX = ACC_W'(1) <<< (MIX_SHIFT - 1);

    localparam logic signed [ACC_W-1:0] OUT_MAX = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] OUT_MIN = -(ACC_W'(1) <<< (SAMPLE_BITS - 1));

    // control
    logic [2:0]    r_state;
    logic [3:0]    r_step;
    logic [SW-1:0] r_k;
    logic          r_dirty;
    logic          r_out_valid;

    // configuration
    logic [23:0]   r_base;
    logic [3:0]    r_first;
    logic [16:0]   r_halo;
    logic [16:0]   r_mix;

    // stage state
    csl_pkg::t_val r_prev [NUM_STAGES];
    csl_pkg::t_val r_ref  [NUM_STAGES];
    csl_pkg::t_val r_thr  [NUM_STAGES];

    // derived coefficients
    logic [QW-1:0]        r_h;
    logic [QW-1:0]        r_omh;
    logic [QW-1:0]        r_h78;
    logic [QW-1:0]        r_omh78;
    logic signed [17:0]   r_wet;
    logic [QW-1:0]        r_dry;

    // working registers
    logic signed [ACC_W-1:0] r_acc;
    csl_pkg::t_val           r_x;
    csl_pkg::t_val           r_dry_in;
    csl_pkg::t_val           r_p;
    csl_pkg::t_val           r_d;
    csl_pkg::t_val           r_t;
    csl_pkg::t_val           r_negt;
    csl_pkg::t_val           r_xa;
    csl_pkg::t_val           r_xb;
    csl_pkg::t_val           r_e1;
    logic signed [RW-1:0]    r_pred;
    logic signed [RW-1:0]    r_dh;
    logic signed [RW-1:0]    r_th;
    logic signed [RW-1:0]    r_dh78;
    logic signed [RW-1:0]    r_th78;
    logic [SAMPLE_BITS-1:0]  r_out;

    // shared multiplier controls
    logic                    w_mul_en;
    logic                    w_phase;
    logic                    w_clear;
    csl_pkg::t_val           w_a;
    logic signed [BW-1:0]    w_b;
    logic signed [ACC_W-1:0] w_rc;
    logic [3:0]              w_sm1;
    logic signed [CHUNK:0]   w_chunk;
    logic signed [CHUNK+BW:0] w_prod;
    logic signed [ACC_W-1:0] w_addend;
    logic signed [ACC_W-1:0] n_acc;

    // misc combinational
    logic                    w_in_acc;
    logic                    w_skip;
    logic                    w_out_load;
    csl_pkg::t_val           w_x_in;
    logic signed [ACC_W-1:0] w_sh16;
    logic signed [ACC_W-1:0] w_sh24;
    logic signed [ACC_W-1:0] w_mix;
    logic [SAMPLE_BITS-1:0]  w_out_sat;
    logic [SW-1:0]           w_km1;
    csl_pkg::t_val           w_tnext;
    csl_pkg::t_val           w_ref_new;
    csl_pkg::t_val           w_base_q;
    logic [QW-1:0]           w_h;
    logic [QW-1:0]           w_m;
    logic signed [18:0]      w_wet;
    logic [17:0]             w_dry2;
    logic [QW-1:0]           w_dry;
    logic [QW-1:0]           w_h78;
    csl_pkg::t_val           w_x1;
    logic signed [ACC_W-1:0] w_v2;
    csl_pkg::t_val           w_x2;

    // handshake
    assign s_axis_tready = (r_state == S_IDLE) && !r_dirty;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out);
    assign w_out_load    = !r_out_valid || m_axis_tready;

    // input word to Q8.31
    assign w_x_in = VW'($signed(s_axis_tdata[SAMPLE_BITS-1:0])) <<< UP_SHIFT;
    assign w_skip = ({1'b0, r_first} >= 5'(NUM_STAGES));

    // coefficients from the registers
    assign w_h    = (r_halo > csl_pkg::ONE_Q16) ? csl_pkg::ONE_Q16 : r_halo;
    assign w_m    = (r_mix > csl_pkg::ONE_Q16) ? csl_pkg::ONE_Q16 : r_mix;
    assign w_wet  = $signed({1'b0, w_m, 1'b0}) - 19'sd65536;
    assign w_dry2 = 18'd131072 - {w_m, 1'b0};
    assign w_dry  = (w_dry2 > 18'(csl_pkg::ONE_Q16)) ? csl_pkg::ONE_Q16 : w_dry2[QW-1:0];
    assign w_base_q = $signed({8'b0, r_base, 8'b0});

    // rounded views of the accumulator (rounding constant added up front)
    assign w_sh16 = r_acc >>> 16;
    assign w_sh24 = r_acc >>> 24;
    assign w_mix  = r_acc >>> MIX_SHIFT;
    assign w_h78  = w_sh16[QW-1:0];

    // threshold ladder step: t + t/phi
    assign w_km1   = r_k - SW'(1);
    assign w_tnext = csl_pkg::sat40(ACC_W'(r_t) + w_sh24);

    // trend reference update
    assign w_ref_new = csl_pkg::sat40(w_sh16);

    // clamp decisions
    assign w_x1 = (r_e1 > r_t) ? r_xa : r_x;
    assign w_v2 = ACC_W'(w_x1) - ACC_W'(r_p) - ACC_W'(r_pred);
    assign w_x2 = (w_v2 < ACC_W'(r_negt)) ? r_xb : w_x1;

    // output saturation
    always_comb begin
        if (w_mix > OUT_MAX) begin
            w_out_sat = OUT_MAX[SAMPLE_BITS-1:0];
        end else if (w_mix < OUT_MIN) begin
            w_out_sat = OUT_MIN[SAMPLE_BITS-1:0];
        end else begin
            w_out_sat = w_mix[SAMPLE_BITS-1:0];
        end
    end

    // operand selection for the shared multiplier
    assign w_sm1 = r_step - 4'd1;

    always_comb begin
        w_mul_en = 1'b0;
        w_phase  = 1'b0;
        w_clear  = 1'b0;
        w_a      = '0;
        w_b      = '0;
        w_rc     = RC_16;
        case (r_state)
            S_TMUL: begin
                w_mul_en = 1'b1;
                w_phase  = r_step[0];
                w_clear  = !r_step[0];
                w_a      = r_t;
                w_b      = B_INVPHI;
                w_rc     = RC_24;
            end
            S_HMUL: begin
                w_mul_en = 1'b1;
                w_phase  = r_step[0];
                w_clear  = !r_step[0];
                w_a      = $signed({23'b0, w_h});
                w_b      = B_HALO78;
            end
            S_STAGE: begin
                if (r_step != ST_LOAD && r_step <= ST_MUL_LAST) begin
                    w_mul_en = 1'b1;
                    w_phase  = w_sm1[0];
                    w_clear  = !w_sm1[0];
                end
                case (w_sm1[3:1])
                    OP_PRED: begin
                        w_a  = r_d;
                        w_b  = B_INVPHI;
                        w_rc = RC_24;
                    end
                    OP_DH: begin
                        w_a = r_d;
                        w_b = $signed({8'b0, r_h});
                    end
                    OP_TH: begin
                        w_a = r_t;
                        w_b = $signed({8'b0, r_omh});
                    end
                    OP_DH78: begin
                        w_a = r_d;
                        w_b = $signed({8'b0, r_h78});
                    end
                    OP_TH78: begin
                        w_a = r_t;
                        w_b = $signed({8'b0, r_omh78});
                    end
                    OP_REF: begin
                        w_a = r_p;
                        w_b = $signed({8'b0, r_omh});
                    end
                    default: begin
                        w_a = r_p;
                        w_b = '0;
                    end
                endcase
            end
            S_MIX: begin
                w_mul_en = (r_step <= ST_MIX_LAST);
                w_phase  = r_step[0];
                w_clear  = (r_step == 4'd0);
                w_a      = r_step[1] ? r_dry_in : r_x;
                w_b      = r_step[1] ? $signed({8'b0, r_dry}) : BW'(r_wet);
                w_rc     = RC_MIX;
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    // multiplier: low slice unsigned, then high slice signed and shifted
    assign w_chunk  = w_phase ? {w_a[VW-1], w_a[VW-1:CHUNK]} : {1'b0, w_a[CHUNK-1:0]};
    assign w_prod   = w_chunk * w_b;
    assign w_addend = w_phase ? (ACC_W'(w_prod) <<< CHUNK) : ACC_W'(w_prod);
    assign n_acc    = (w_clear ? w_rc : r_acc) + w_addend;

    // sequencer, configuration and stage state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_k         <= '0;
            r_dirty     <= 1'b1;
            r_out_valid <= 1'b0;
            r_base      <= csl_pkg::BASE_RST;
            r_first     <= csl_pkg::FIRST_RST;
            r_halo      <= csl_pkg::HALO_RST;
            r_mix       <= csl_pkg::MIX_RST;
            for (int i = 0; i < NUM_STAGES; i++) begin
                r_prev[i] <= '0;
                r_ref[i]  <= '0;
            end
        end else begin
            // output word loaded, or taken
            if (r_state == S_MIX && r_step == ST_OUT && w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (r_dirty) begin
                        if (!i_cfg_we) begin
                            r_dirty <= 1'b0;
                        end
                        r_state <= S_PREP;
                    end else if (w_in_acc) begin
                        r_step <= '0;
                        if (w_skip) begin
                            r_state <= S_MIX;
                        end else begin
                            r_k     <= r_first[SW-1:0];
                            r_state <= S_STAGE;
                        end
                    end
                end
                S_PREP: begin
                    r_k     <= SW'(NUM_STAGES - 1);
                    r_step  <= '0;
                    r_state <= (NUM_STAGES > 1) ? S_TMUL : S_HMUL;
                end
                S_TMUL: begin
                    if (r_step[0]) begin
                        r_step  <= '0;
                        r_state <= S_TCAP;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                S_TCAP: begin
                    r_k     <= w_km1;
                    r_state <= (r_k == SW'(1)) ? S_HMUL : S_TMUL;
                end
                S_HMUL: begin
                    if (r_step[0]) begin
                        r_step  <= '0;
                        r_state <= S_HCAP;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                S_HCAP: begin
                    r_state <= S_IDLE;
                end
                S_STAGE: begin
                    if (r_step == ST_EVAL) begin
                        r_ref[r_k] <= w_ref_new;
                    end
                    if (r_step == ST_DONE) begin
                        r_prev[r_k] <= w_x2;
                        r_step      <= '0;
                        if (r_k == SW'(NUM_STAGES - 1)) begin
                            r_state <= S_MIX;
                        end else begin
                            r_k <= r_k + SW'(1);
                        end
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                S_MIX: begin
                    if (r_step == ST_OUT) begin
                        if (w_out_load) begin
                            r_step  <= '0;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // register writes; any write rebuilds the derived terms
            if (i_cfg_we) begin
                r_dirty <= 1'b1;
                case (i_cfg_addr)
                    csl_pkg::REG_BASE:  r_base  <= i_cfg_data[23:0];
                    csl_pkg::REG_FIRST: r_first <= i_cfg_data[3:0];
                    csl_pkg::REG_HALO:  r_halo  <= i_cfg_data[16:0];
                    csl_pkg::REG_MIX:   r_mix   <= i_cfg_data[16:0];
                    default:            ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_acc <= n_acc;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_x      <= w_x_in;
                    r_dry_in <= w_x_in;
                end
            end
            S_PREP: begin
                r_t                    <= w_base_q;
                r_thr[NUM_STAGES - 1]  <= w_base_q;
                r_h                    <= w_h;
                r_omh                  <= csl_pkg::ONE_Q16 - w_h;
                r_wet                  <= 18'(w_wet);
                r_dry                  <= w_dry;
            end
            S_TCAP: begin
                r_thr[w_km1] <= w_tnext;
                r_t          <= w_tnext;
            end
            S_HCAP: begin
                r_h78   <= w_h78;
                r_omh78 <= csl_pkg::ONE_Q16 - w_h78;
            end
            S_STAGE: begin
                case (r_step)
                    ST_LOAD: begin
                        r_p    <= r_prev[r_k];
                        r_d    <= csl_pkg::sat40(ACC_W'(r_prev[r_k]) - ACC_W'(r_ref[r_k]));
                        r_t    <= r_thr[r_k];
                        r_negt <= -r_thr[r_k];
                    end
                    ST_CAP_PRED: r_pred <= w_sh24[RW-1:0];
                    ST_CAP_DH:   r_dh   <= w_sh16[RW-1:0];
                    ST_CAP_TH:   r_th   <= w_sh16[RW-1:0];
                    ST_CAP_DH78: r_dh78 <= w_sh16[RW-1:0];
                    ST_CAP_TH78: r_th78 <= w_sh16[RW-1:0];
                    ST_EVAL: begin
                        // clamp targets and first prediction error
                        r_xa <= csl_pkg::sat40(ACC_W'(r_p) - ACC_W'(r_dh) + ACC_W'(r_th));
                        r_xb <= csl_pkg::sat40(ACC_W'(r_p) - ACC_W'(r_dh78) - ACC_W'(r_th78));
                        r_e1 <= csl_pkg::sat40(ACC_W'(r_x) - ACC_W'(r_p) - ACC_W'(r_pred));
                    end
                    ST_DONE: r_x <= w_x2;
                    default: r_x <= r_x;
                endcase
            end
            S_MIX: begin
                if (r_step == ST_OUT && w_out_load) begin
                    r_out <= w_out_sat;
                end
            end
            default: begin
                r_out <= r_out;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== tb/csl_tb_pkg.sv =====
`default_nettype none

package csl_tb_pkg;

    localparam int NSTG  = csl_pkg::NUM_STAGES_DEF;
    localparam int SBITS = csl_pkg::SAMPLE_BITS_DEF;
    localparam int UP    = 32 - SBITS;   // sample to Q8.31 shift

    localparam longint VAL_MAX = (64'sd1 <<< 39) - 64'sd1;
    localparam longint VAL_MIN = -(64'sd1 <<< 39);

    // clamp to the signed 40-bit stage range
    function automatic longint clamp40(input longint v);
        if (v > VAL_MAX) begin
            return VAL_MAX;
        end
        if (v < VAL_MIN) begin
            return VAL_MIN;
        end
        return v;
    endfunction

    // floor((v + 2^(n-1)) / 2^n)
    function automatic longint round_shift(input longint v, input int n);
        if (n == 0) begin
            return v;
        end
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint mul_round(input longint a, input longint b, input int n);
        return round_shift(a * b, n);
    endfunction

    class slew_scoreboard;
        logic [23:0]      base_thr;
        logic [3:0]       first_stg;
        logic [16:0]      halo;
        logic [16:0]      mix;
        longint           prev_val[NSTG];
        longint           trend_ref[NSTG];
        logic [SBITS-1:0] expected_samples[$];
        int               mismatches;

        function new();
            base_thr  = csl_pkg::BASE_RST;
            first_stg = csl_pkg::FIRST_RST;
            halo      = csl_pkg::HALO_RST;
            mix       = csl_pkg::MIX_RST;
            foreach (prev_val[k]) begin
                prev_val[k]  = 0;
                trend_ref[k] = 0;
            end
            mismatches = 0;
        endfunction

        function void write_reg(input logic [csl_pkg::CFG_AW-1:0] idx,
                                input logic [csl_pkg::CFG_DW-1:0] value);
            case (idx)
                csl_pkg::REG_BASE:  base_thr  = value[23:0];
                csl_pkg::REG_FIRST: first_stg = value[3:0];
                csl_pkg::REG_HALO:  halo      = value[16:0];
                csl_pkg::REG_MIX:   mix       = value[16:0];
                default: ;
            endcase
        endfunction

        // run one sample through the active stages and the wet/dry mix
        function logic [SBITS-1:0] limit_sample(input logic [SBITS-1:0] smp);
            longint thr[NSTG];
            longint one, invphi, h, h78, m, wet, dry, dry_in, x, acc, lim;
            longint p, d, pred, t, err;
            one    = longint'(csl_pkg::ONE_Q16);
            invphi = longint'(csl_pkg::INVPHI_Q24);
            dry_in = longint'($signed(smp)) <<< UP;

            h   = (halo > csl_pkg::ONE_Q16) ? one : longint'(halo);
            h78 = mul_round(h, longint'(csl_pkg::HALO78_Q16), 16);
            m   = (mix > csl_pkg::ONE_Q16) ? one : longint'(mix);
            wet = 2 * m - one;
            dry = 2 * one - 2 * m;
            if (dry > one) begin
                dry = one;
            end

            // threshold ladder, tightest stage last
            thr[NSTG-1] = longint'(base_thr) <<< 8;
            for (int k = NSTG - 1; k > 0; k--) begin
                thr[k-1] = clamp40(thr[k] + mul_round(thr[k], invphi, 24));
            end

            x = dry_in;
            for (int k = int'(first_stg); k < NSTG; k++) begin
                p    = prev_val[k];
                d    = clamp40(p - trend_ref[k]);
                pred = mul_round(d, invphi, 24);
                t    = thr[k];
                err  = clamp40((x - p) - pred);
                if (err > t) begin
                    x = clamp40(p - mul_round(d, h, 16) + mul_round(t, one - h, 16));
                end
                err = clamp40((x - p) - pred);
                // negative side uses the 0.78 halo
                if (-err > t) begin
                    x = clamp40(p - mul_round(d, h78, 16) - mul_round(t, one - h78, 16));
                end
                trend_ref[k] = clamp40(mul_round(p, one - h, 16));
                prev_val[k]  = x;
            end

            acc = round_shift(x * wet + dry_in * dry, 16 + UP);
            lim = 64'sd1 <<< (SBITS - 1);
            if (acc > lim - 1) begin
                acc = lim - 1;
            end
            if (acc < -lim) begin
                acc = -lim;
            end
            return acc[SBITS-1:0];
        endfunction

        function void note_input(input logic [SBITS-1:0] smp);
            expected_samples.push_back(limit_sample(smp));
        endfunction

        function void check_output(input logic [SBITS-1:0] got, input realtime stamp);
            logic [SBITS-1:0] want;
            if (expected_samples.size() == 0) begin
                mismatches++;
                $display("t=%0.1f ns: unexpected sample_out word, expected none, got %0d",
                         stamp, $signed(got));
                return;
            end
            want = expected_samples.pop_front();
            if (want !== got) begin
                mismatches++;
                $display("t=%0.1f ns: sample_out mismatch, expected %0d, got %0d",
                         stamp, $signed(want), $signed(got));
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

endpackage

`default_nettype wire

// ===== tb/cascaded_slew_limiter_tb.sv =====
`default_nettype none

module cascaded_slew_limiter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SBITS        = csl_tb_pkg::SBITS;
    localparam int DW           = ((SBITS + 7) / 8) * 8;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int HOLD_CYCLES  = 1000;
    localparam int DRAIN_CYCLES = 200;
    localparam int IDLE_PCT     = 35;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [DW-1:0]               s_axis_tdata;   // sample_in
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [DW-1:0]               m_axis_tdata;   // sample_out
    logic                        i_cfg_we;
    logic [csl_pkg::CFG_AW-1:0]  i_cfg_addr;
    logic [csl_pkg::CFG_DW-1:0]  i_cfg_data;

    logic calm;        // no idling on either side
    logic hold_req;    // ask the receiver for one long hold-off
    bit   hold_taken;
    int   hold_left;
    int   cycle_count;
    int   walk_pos;

    csl_tb_pkg::slew_scoreboard sb = new();

    logic [SBITS-1:0] directed[22] = '{
        24'h000000, 24'h000000, 24'h000000, 24'h000001, 24'hFFFFFF,
        24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h555555,
        24'hAAAAAA, 24'h000064, 24'h0000C8, 24'h002328, 24'hFFDCD8,
        24'h400000, 24'hC00000, 24'h7FFFFF, 24'h7FFFFF, 24'h000000,
        24'h000000, 24'h000000
    };

    cascaded_slew_limiter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL cascaded_slew_limiter");
        $finish;
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        hold_taken = 1'b0;
        hold_left  = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // check every accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_output(m_axis_tdata[SBITS-1:0], $realtime);
        end
    end

    // offer one word, leave tvalid high once it is taken
    task automatic send_word(input logic [SBITS-1:0] smp);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(smp);
    endtask

    // stop sending and wait for every result; ends on a rising edge
    task automatic drain_phase();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [csl_pkg::CFG_AW-1:0] idx, input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value[csl_pkg::CFG_DW-1:0];
        sb.write_reg(idx, value[csl_pkg::CFG_DW-1:0]);
        @(posedge i_clk);
    endtask

    task automatic load_settings(input int base, input int first, input int h, input int m);
        write_reg(csl_pkg::REG_BASE, base);
        write_reg(csl_pkg::REG_FIRST, first);
        write_reg(csl_pkg::REG_HALO, h);
        write_reg(csl_pkg::REG_MIX, m);
        i_cfg_we <= 1'b0;
    endtask

    // audio-like segments: walks, square bursts, extremes, white noise
    task automatic send_random(input int count);
        int sent;
        int kind;
        int len;
        int step;
        int half;
        int amp;
        logic [SBITS-1:0] pick;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(0, 99);
            len  = $urandom_range(4, 40);
            if (kind < 45) begin
                step = 1 << $urandom_range(0, 21);
                for (int i = 0; i < len; i++) begin
                    walk_pos = walk_pos + $urandom_range(0, 2 * step) - step;
                    if (walk_pos > 8388607) begin
                        walk_pos = 8388607;
                    end
                    if (walk_pos < -8388608) begin
                        walk_pos = -8388608;
                    end
                    send_word(walk_pos[SBITS-1:0]);
                end
            end else if (kind < 65) begin
                amp  = $urandom_range(0, 8388607) >> $urandom_range(0, 16);
                half = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    pick = ((i / half) % 2 != 0) ? SBITS'(-amp) : SBITS'(amp);
                    send_word(pick);
                end
            end else if (kind < 80) begin
                for (int i = 0; i < len; i++) begin
                    case ($urandom_range(0, 4))
                        0:       pick = 24'h7FFFFF;
                        1:       pick = 24'h800000;
                        2:       pick = 24'h000000;
                        3:       pick = 24'hFFFFFF;
                        default: pick = 24'h000001;
                    endcase
                    send_word(pick);
                end
            end else begin
                for (int i = 0; i < len; i++) begin
                    send_word(SBITS'($urandom_range(0, 24'hFFFFFF)));
                end
            end
            sent += len;
        end
    endtask

    initial begin
        int b;
        int f;
        int h;
        int m;
        walk_pos = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_data    <= '0;
        calm          <= 1'b0;
        hold_req      <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words at reset settings
        foreach (directed[i]) begin
            send_word(directed[i]);
        end
        drain_phase();

        // zero threshold, all stages, no halo, full wet
        load_settings(0, 0, 0, 65536);
        send_random(120);
        drain_phase();

        // widest threshold, last stage only, full halo, wet inverted
        load_settings(24'hFFFFFF, 9, 65536, 0);
        send_random(120);
        drain_phase();

        // no stage runs; halo and mix above one
        load_settings(24'h9A5C33, 15, 131071, 131071);
        send_random(100);
        drain_phase();

        // no idling, receiver holds off while the sender keeps offering
        load_settings(8388, 0, 32768, 32768);
        calm     <= 1'b1;
        hold_req <= 1'b1;
        send_random(140);
        drain_phase();
        calm <= 1'b0;

        // random settings
        for (int ph = 0; ph < 8; ph++) begin
            b = $urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 23);
            f = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 9) : $urandom_range(0, 15);
            h = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 65536)
                                            : $urandom_range(65537, 131071);
            m = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 65536)
                                            : $urandom_range(65537, 131071);
            load_settings(b, f, h, m);
            send_random(115);
            drain_phase();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS cascaded_slew_limiter");
        end else begin
            $display("FAIL cascaded_slew_limiter");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/csl_pkg.sv
sv/cascaded_slew_limiter.sv
tb/csl_tb_pkg.sv
tb/cascaded_slew_limiter_tb.sv
